[rtl/core/bsr_pkg.sv]
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the bitmap set/test/run finder.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int POS_W   = 16;
  localparam int COUNT_W = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [1:0] ACT_SET  = 2'd0;
  localparam logic [1:0] ACT_TEST = 2'd1;
  localparam logic [1:0] ACT_FIND = 2'd2;

  typedef struct packed {
    logic               hit;
    logic               found;
    logic [POS_W-1:0]   run_low;
    logic [POS_W-1:0]   run_high;
    logic [COUNT_W-1:0] ones_count;
  } bsr_result_t;

endpackage

[rtl/core/bitmap_set_test_run_finder.sv]
// Set and test pass from the accepted item through MUL, QUO, REM and EVAL to DONE,
// skipping EVAL when the position is outside the window or the action is unused.
// A find walks words in EVAL seeking the first one and in RUN following the run;
// the word holding the first one is examined by both.
// One item at a time: the next is taken the cycle after its result is registered.
// Synchronous reset, then a clearing pass over all MAP_BITS/WORD_BITS words (128 by default).
// ----------------------------------------------------------------------------
// bitmap_set_test_run_finder
// Record-number bitmap with set, test and find-next-run items.
// ----------------------------------------------------------------------------
module bitmap_set_test_run_finder #(
  parameter int MAP_BITS  = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [bsr_pkg::POS_W-1:0]     position,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsr_pkg::POS_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic                          found,
  output logic [bsr_pkg::POS_W-1:0]     run_low,
  output logic [bsr_pkg::POS_W-1:0]     run_high,
  output logic [bsr_pkg::COUNT_W-1:0]   ones_count
);

  import bsr_pkg::*;

  localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 res_valid;
  logic                 res_ready;
  bsr_result_t          res;
  bsr_result_t          out_q;

  bsr_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bsr_seq #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .position  (position),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees the sequencer for the next item
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign hit        = out_q.hit;
  assign found      = out_q.found;
  assign run_low    = out_q.run_low;
  assign run_high   = out_q.run_high;
  assign ones_count = out_q.ones_count;

endmodule

[rtl/core/bsr_ram.sv]
// ----------------------------------------------------------------------------
// bsr_ram
// Single-port synchronous word memory with registered read.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/bsr_seq.sv]
// ----------------------------------------------------------------------------
// bsr_seq
// Sequencer: locates the word of a position, then reads, tests or sets it,
// or walks words to find the next run of ones.
// ----------------------------------------------------------------------------
module bsr_seq #(
  parameter int MAP_BITS  = 4096,
  parameter int WORD_BITS = 32,
  parameter int NUM_WORDS = 128,
  parameter int AW        = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [bsr_pkg::POS_W-1:0]   position,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bsr_pkg::POS_W-1:0]   cfg_data,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_addr,
  output logic [WORD_BITS-1:0]        mem_wdata,
  input  logic [WORD_BITS-1:0]        mem_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bsr_pkg::bsr_result_t        res
);

  import bsr_pkg::*;

  localparam int OW    = $clog2(WORD_BITS);
  localparam int REW   = OW + 1;
  localparam int SHIFT = 22;
  localparam int PW    = SHIFT + POS_W;
  localparam logic [PW-1:0]   RECIP    = PW'((64'd1 << SHIFT) / WORD_BITS);
  localparam logic [OW-1:0]   BIT_TOP  = OW'(WORD_BITS - 1);
  localparam logic [AW-1:0]   LAST     = AW'(NUM_WORDS - 1);
  localparam logic [POS_W-1:0] WSTEP   = POS_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] LSB1 = WORD_BITS'(1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_QUO  = 3'd3;
  localparam logic [2:0] S_REM  = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;
  localparam logic [2:0] S_RUN  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // index from the top bit of the first set bit
  function automatic logic [OW-1:0] first_one(input logic [WORD_BITS-1:0] v);
    logic [OW-1:0] idx;
    logic          seen;
    idx  = '0;
    seen = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!seen && v[WORD_BITS-1-i]) begin
        idx  = OW'(i);
        seen = 1'b1;
      end
    end
    return idx;
  endfunction

  logic [2:0]           state;
  logic [1:0]           act;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     rel;
  logic                 below;
  logic                 above;
  logic [PW-1:0]        prod;
  logic [POS_W-1:0]     q_est;
  logic [REW-1:0]       rem_est;
  logic [AW-1:0]        word_idx;
  logic [OW-1:0]        off;
  logic [POS_W-1:0]     word_abs;
  logic [WORD_BITS-1:0] held;
  logic                 fresh;
  logic [COUNT_W-1:0]   count;
  logic [POS_W-1:0]     base;
  logic                 r_hit;
  logic                 r_found;
  logic [POS_W-1:0]     r_lo;
  logic [POS_W-1:0]     r_hi;

  logic [POS_W:0]       diff;
  logic [POS_W-1:0]     quo_mul;
  logic [POS_W-1:0]     q_fix;
  logic [OW-1:0]        off_fix;
  logic [AW-1:0]        start_idx;
  logic [WORD_BITS-1:0] eval_word;
  logic [WORD_BITS-1:0] seek_bits;
  logic [WORD_BITS-1:0] zero_bits;
  logic [WORD_BITS-1:0] set_mask;
  logic [OW-1:0]        p_idx;
  logic [OW-1:0]        z_idx;
  logic                 bit_sel;
  logic                 is_last;
  logic                 outside;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign res_valid = (state == S_DONE);

  assign res.hit        = r_hit;
  assign res.found      = r_found;
  assign res.run_low    = r_lo;
  assign res.run_high   = r_hi;
  assign res.ones_count = count;

  always_comb begin
    diff      = {1'b0, position} - {1'b0, base};
    quo_mul   = POS_W'(prod[SHIFT +: POS_W] * WSTEP);
    if (rem_est >= REW'(WORD_BITS)) begin
      q_fix   = q_est + POS_W'(1);
      off_fix = OW'(rem_est - REW'(WORD_BITS));
    end else begin
      q_fix   = q_est;
      off_fix = OW'(rem_est);
    end
    start_idx = below ? '0 : q_fix[AW-1:0];
    outside   = below || above;
    eval_word = (state == S_RUN && !fresh) ? held : mem_rdata;
    seek_bits = eval_word & (ONES >> off);
    zero_bits = ~eval_word & (ONES >> off);
    p_idx     = first_one(seek_bits);
    z_idx     = first_one(zero_bits);
    set_mask  = LSB1 << (BIT_TOP - off);
    bit_sel   = |(mem_rdata & set_mask);
    is_last   = (word_idx == LAST);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = word_idx;
    mem_wdata = mem_rdata | set_mask;
    case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_REM: begin
        mem_addr = start_idx;
      end
      S_EVAL: begin
        if (act == ACT_SET && !bit_sel) begin
          mem_we = 1'b1;
        end else if (act == ACT_FIND && seek_bits == '0 && !is_last) begin
          mem_addr = word_idx + AW'(1);
        end
      end
      S_RUN: begin
        if (zero_bits == '0 && !is_last) begin
          mem_addr = word_idx + AW'(1);
        end
      end
      default: begin
        mem_addr = word_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      word_idx <= '0;
      count    <= '0;
      base     <= '0;
    end else begin
      if (cfg_valid) begin
        base <= cfg_data;
      end
      case (state)
        S_CLR: begin
          if (is_last) begin
            state    <= S_IDLE;
            word_idx <= '0;
          end else begin
            word_idx <= word_idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act     <= action;
            pos     <= position;
            rel     <= diff[POS_W-1:0];
            below   <= diff[POS_W];
            above   <= !diff[POS_W] && ({16'd0, diff[POS_W-1:0]} >= 32'(MAP_BITS));
            r_hit   <= 1'b0;
            r_found <= 1'b0;
            r_lo    <= '0;
            r_hi    <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PW'(rel) * RECIP;
          state <= S_QUO;
        end
        S_QUO: begin
          q_est   <= prod[SHIFT +: POS_W];
          rem_est <= REW'(rel - quo_mul);
          state   <= S_REM;
        end
        S_REM: begin
          word_idx <= start_idx;
          off      <= below ? '0 : off_fix;
          word_abs <= below ? base : (pos - POS_W'(off_fix));
          if (act == ACT_FIND) begin
            state <= above ? S_DONE : S_EVAL;
          end else if (act == ACT_SET || act == ACT_TEST) begin
            state <= outside ? S_DONE : S_EVAL;
          end else begin
            state <= S_DONE;
          end
        end
        S_EVAL: begin
          if (act == ACT_SET) begin
            if (!bit_sel && count != COUNT_MAX) begin
              count <= count + COUNT_W'(1);
            end
            state <= S_DONE;
          end else if (act == ACT_TEST) begin
            r_hit <= bit_sel;
            state <= S_DONE;
          end else if (seek_bits != '0) begin
            held    <= mem_rdata;
            off     <= p_idx;
            fresh   <= 1'b0;
            r_found <= 1'b1;
            r_lo    <= word_abs + POS_W'(p_idx);
            state   <= S_RUN;
          end else if (is_last) begin
            state <= S_DONE;
          end else begin
            word_idx <= word_idx + AW'(1);
            word_abs <= word_abs + WSTEP;
            off      <= '0;
          end
        end
        S_RUN: begin
          if (zero_bits != '0) begin
            r_hi  <= word_abs + POS_W'(z_idx) - POS_W'(1);
            state <= S_DONE;
          end else if (is_last) begin
            // run reaches the top of the map
            r_hi  <= word_abs + WSTEP - POS_W'(1);
            state <= S_DONE;
          end else begin
            word_idx <= word_idx + AW'(1);
            word_abs <= word_abs + WSTEP;
            off      <= '0;
            fresh    <= 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/tb_bitmap_set_test_run_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_set_test_run_finder
// Drives set, test and find-run items into the record bitmap and checks
// each result against a bit-level model of the window, the count of ones
// and the base register. Four random phases vary input idling and output
// stalls, and the base is rewritten before each.
// ----------------------------------------------------------------------------
module tb_bitmap_set_test_run_finder;
  import bsr_pkg::*;

  localparam int MAP_BITS   = 4096;
  localparam int WORD_BITS  = 32;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 8;
  localparam int PRINT_CAP  = 40;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [1:0]       act;
    logic [POS_W-1:0] pos;
    bit               drain;
  } bitmap_op_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = '0;
  logic [POS_W-1:0]   position = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [POS_W-1:0]   cfg_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic               found;
  logic [POS_W-1:0]   run_low;
  logic [POS_W-1:0]   run_high;
  logic [COUNT_W-1:0] ones_count;

  // model of the block
  bit                 map_bits [MAP_BITS];
  logic [COUNT_W-1:0] ones_total = '0;
  logic [POS_W-1:0]   window_base = '0;

  bitmap_op_t  pending_ops[$];
  bsr_result_t awaited_results[$];
  bsr_result_t seen, want;

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  in_taken = 1'b0;

  bitmap_set_test_run_finder #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .position   (position),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .found      (found),
    .run_low    (run_low),
    .run_high   (run_high),
    .ones_count (ones_count)
  );

  always #6 clk = ~clk;

  // applies one item to the model and returns the result it should give
  function automatic bsr_result_t bitmap_apply(input logic [1:0] act,
                                               input logic [POS_W-1:0] pos);
    bsr_result_t r;
    int rel, start, stop;
    bit in_window;
    r = '0;
    rel = int'(pos) - int'(window_base);
    in_window = (rel >= 0) && (rel < MAP_BITS);
    case (act)
      ACT_SET: begin
        if (in_window && !map_bits[rel]) begin
          map_bits[rel] = 1'b1;
          if (ones_total < COUNT_MAX) ones_total++;
        end
      end
      ACT_TEST: begin
        r.hit = in_window && map_bits[rel];
      end
      ACT_FIND: begin
        // below the window the search starts at bit zero
        start = (rel < 0) ? 0 : rel;
        while (start < MAP_BITS && !map_bits[start]) start++;
        if (start < MAP_BITS) begin
          stop = start;
          while (stop + 1 < MAP_BITS && map_bits[stop + 1]) stop++;
          r.found    = 1'b1;
          r.run_low  = window_base + POS_W'(start);
          r.run_high = window_base + POS_W'(stop);
        end
      end
      default: ;
    endcase
    r.ones_count = ones_total;
    return r;
  endfunction

  function automatic logic [POS_W-1:0] window_pos(input int off);
    return window_base + POS_W'(off);
  endfunction

  task automatic push_op(input logic [1:0] act, input logic [POS_W-1:0] pos,
                         input bit drain = 1'b0);
    bitmap_op_t op;
    op.act = act;
    op.pos = pos;
    op.drain = drain;
    pending_ops = {pending_ops, op};
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0d] %s: got %0d, want %0d", cycle_count, what, got, exp_val);
  endtask

  // nothing queued, nothing on the input, nothing outstanding
  task automatic wait_quiet();
    @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_base(input logic [POS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    window_base = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_mixed_ops(input int n);
    int made, len, off, pick;
    bit drained;
    made = 0;
    drained = 1'b0;
    while (made < n) begin
      // once per phase the sender holds back until the output has drained
      if (!drained && made >= n / 2) begin
        drained = 1'b1;
        push_op(ACT_TEST, window_pos($urandom_range(0, MAP_BITS - 1)), 1'b1);
        made++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // consecutive sets build runs, some across word boundaries
        len = $urandom_range(1, 40);
        off = $urandom_range(0, MAP_BITS - 1);
        for (int k = 0; k < len; k++) push_op(ACT_SET, window_pos(off + k));
        made += len;
      end else if (pick < 45) begin
        push_op(ACT_FIND, window_pos($urandom_range(0, MAP_BITS - 1)));
        made++;
      end else if (pick < 62) begin
        push_op(ACT_TEST, window_pos($urandom_range(0, MAP_BITS - 1)));
        made++;
      end else if (pick < 75) begin
        push_op(ACT_SET, window_pos($urandom_range(0, MAP_BITS - 1)));
        made++;
      end else if (pick < 87) begin
        // around the top edge of the window
        off = $urandom_range(MAP_BITS - 40, MAP_BITS + 8);
        push_op(2'($urandom_range(0, 2)), window_pos(off));
        made++;
      end else begin
        push_op(2'($urandom_range(0, 3)), POS_W'($urandom_range(0, 65535)));
        made++;
      end
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input logic [POS_W-1:0] base,
                           input int n);
    wait_quiet();
    send_idle_pct = idle_pct;
    stall_pct = stall;
    write_base(base);
    queue_mixed_ops(n);
  endtask

  // input driver and output ready
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && !in_taken) begin
        // hold the item until it is taken
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain && awaited_results.size() != 0) &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        action   <= pending_ops[0].act;
        position <= pending_ops[0].pos;
        void'(pending_ops.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // accepted items and results
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst) begin
      in_taken = in_valid && in_ready;
      if (in_taken) awaited_results = {awaited_results, bitmap_apply(action, position)};
      if (out_valid && out_ready) begin
        seen = '{hit, found, run_low, run_high, ones_count};
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (seen.hit !== want.hit)
            report_mismatch("hit", int'(seen.hit), int'(want.hit));
          if (seen.found !== want.found)
            report_mismatch("found", int'(seen.found), int'(want.found));
          if (seen.run_low !== want.run_low)
            report_mismatch("run_low", int'(seen.run_low), int'(want.run_low));
          if (seen.run_high !== want.run_high)
            report_mismatch("run_high", int'(seen.run_high), int'(want.run_high));
          if (seen.ones_count !== want.ones_count)
            report_mismatch("ones_count", int'(seen.ones_count), int'(want.ones_count));
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty map, duplicate set, top of window, out of window
    write_base(16'd0);
    push_op(ACT_FIND, 16'd0);
    push_op(ACT_TEST, 16'd0);
    push_op(ACT_SET, 16'd0);
    push_op(ACT_SET, 16'd0);
    push_op(ACT_TEST, 16'd0);
    push_op(ACT_SET, 16'd1);
    push_op(ACT_SET, 16'd2);
    push_op(ACT_FIND, 16'd0);
    push_op(ACT_SET, 16'd4095);
    push_op(ACT_SET, 16'd4094);
    push_op(ACT_FIND, 16'd3000);
    push_op(ACT_SET, 16'd4096);
    push_op(ACT_TEST, 16'd4096);
    push_op(ACT_FIND, 16'd4096);
    push_op(ACT_TEST, 16'hFFFF);
    push_op(ACT_SET, 16'hFFFF);
    push_op(ACT_SPARE, 16'hFFFF);
    push_op(ACT_FIND, 16'd3);
    wait_quiet();

    // moved base keeps the bits, find from below the window
    write_base(16'd1024);
    push_op(ACT_FIND, 16'd0);
    push_op(ACT_TEST, 16'd1023);
    push_op(ACT_SET, 16'd1000);
    push_op(ACT_TEST, 16'd1024);
    wait_quiet();

    // unaligned top base, reported run wraps past the top of the position range
    write_base(16'hFFFF);
    push_op(ACT_FIND, 16'd0);
    push_op(ACT_SET, 16'hFFFF);
    push_op(ACT_TEST, 16'hFFFF);

    run_phase(0, 0, 16'd0, 150);
    run_phase(52, 0, 16'd61440, 150);
    run_phase(0, 52, POS_W'($urandom_range(0, 1919) * WORD_BITS), 150);
    run_phase(34, 34, POS_W'($urandom_range(0, 65535)), 150);

    wait_quiet();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
